FILE: design/gdr_pkg.sv
// ---------------------------------------------------------------------------
// gdr_pkg: shared constants for the grid raycaster
// Default sizes, the request codes and the saturation limits.
// ---------------------------------------------------------------------------
`default_nettype none
package gdr_pkg;
  localparam int MAP_DIM_DEF     = 32;
  localparam int SCREEN_SIZE_DEF = 512;
  localparam int FRAC_BITS_DEF   = 16;
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_CAST  = 1'b1;
  localparam logic [23:0] DIST_MAX   = 24'hFFFFFF;
  localparam logic [15:0] HEIGHT_MAX = 16'hFFFF;
endpackage
`default_nettype wire

FILE: design/gdr_div.sv
// ---------------------------------------------------------------------------
// gdr_div: iterative restoring divider
// One quotient bit per cycle, numerator and divisor of WIDTH bits.
// ---------------------------------------------------------------------------
`default_nettype none
module gdr_div #(
  parameter int WIDTH = 48
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [WIDTH-1:0] num,
  input  wire logic [WIDTH-1:0] den,
  output logic                  done,
  output logic [WIDTH-1:0]      quo
);
  localparam int CW = $clog2(WIDTH + 1);
  logic [WIDTH-1:0] rem_r, q_r, d_r;
  logic [CW-1:0]    cnt_r;
  logic             busy_r;
  logic [WIDTH:0]   trial;

  assign trial = {rem_r, q_r[WIDTH-1]} - {1'b0, d_r};
  assign quo   = q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done   <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        rem_r  <= '0;
        q_r    <= num;
        d_r    <= den;
        cnt_r  <= CW'(WIDTH);
      end else if (busy_r) begin
        if (!trial[WIDTH]) begin
          rem_r <= trial[WIDTH-1:0];
          q_r   <= {q_r[WIDTH-2:0], 1'b1};
        end else begin
          rem_r <= {rem_r[WIDTH-2:0], q_r[WIDTH-1]};
          q_r   <= {q_r[WIDTH-2:0], 1'b0};
        end
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

FILE: design/grid_dda_raycast.sv
// ---------------------------------------------------------------------------
// grid_dda_raycast: DDA ray caster over a stored grid map
// Keeps the map in a block memory, walks a ray to the first wall and returns
// distance, column height and draw rows.
// ---------------------------------------------------------------------------
//  channel | direction | handshake        | payload
//  in_*    | input     | in_valid/in_stall | request item
//  out_*   | output    | out_valid/out_stall | result item
//
//  Flow: writes can follow back to back. A cast is accepted, then passes a
//  setup state, then per grid step the step, map read and check states (up
//  to 2*MAP_DIM+2 steps), for a hit two serial divisions on the shared
//  divider, and a state that loads the result; the walk over the single map
//  read port and the shared divider set its length.
//  Reset: a clearing pass writes zero to every cell, with in_stall high.
//  A held result stalls the next cast at its end only.
// ---------------------------------------------------------------------------
`default_nettype none
module grid_dda_raycast #(
  parameter int MAP_DIM     = gdr_pkg::MAP_DIM_DEF,
  parameter int SCREEN_SIZE = gdr_pkg::SCREEN_SIZE_DEF,
  parameter int FRAC_BITS   = gdr_pkg::FRAC_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_req_type,
  input  wire logic [4:0]  in_cell_x,
  input  wire logic [4:0]  in_cell_y,
  input  wire logic [7:0]  in_cell_value,
  input  wire logic [23:0] in_pos_x,
  input  wire logic [23:0] in_pos_y,
  input  wire logic signed [17:0] in_dir_x,
  input  wire logic signed [17:0] in_dir_y,
  input  wire logic [23:0] in_delta_x,
  input  wire logic [23:0] in_delta_y,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_hit_found,
  output logic             out_hit_side,
  output logic [4:0]       out_hit_cell_x,
  output logic [4:0]       out_hit_cell_y,
  output logic [23:0]      out_wall_distance,
  output logic [15:0]      out_line_height,
  output logic [8:0]       out_draw_start,
  output logic [8:0]       out_draw_end
);
  import gdr_pkg::*;

  localparam int CB    = $clog2(MAP_DIM);          // cell coordinate bits
  localparam int CELLS = MAP_DIM * MAP_DIM;
  localparam int AB    = $clog2(CELLS);
  localparam int SB    = 50;                       // side distance width
  localparam int DW    = FRAC_BITS + 32;           // divider width
  localparam int HALF  = SCREEN_SIZE / 2;
  localparam int NB    = $clog2(2 * MAP_DIM + 3);  // step counter bits

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_SETUP, S_STEP, S_READ, S_CHECK,
    S_DIV1, S_DIV1W, S_DIV2, S_DIV2W, S_OUT
  } state_t;

  state_t state_r;
  logic [AB-1:0] clr_r;
  logic [7:0] mem [CELLS];
  logic [7:0] rd_q;

  // cast registers
  logic [24:0] px_r, py_r;
  logic signed [17:0] dx_r, dy_r;
  logic [23:0] delx_r, dely_r;
  logic signed [CB+1:0] mx_r, my_r;
  logic [SB-1:0] sdx_r, sdy_r;
  logic side_r;
  logic [NB-1:0] n_r;
  logic [23:0] dist_r;

  // memory port
  logic we;
  logic [AB-1:0] waddr, raddr;
  logic [7:0] wdata;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rd_q <= mem[raddr];
  end

  // divider
  logic div_start, div_done;
  logic [DW-1:0] div_num, div_den, div_q;
  gdr_div #(.WIDTH(DW)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start),
    .num(div_num), .den(div_den), .done(div_done), .quo(div_q)
  );

  logic in_inside;
  assign in_inside = (32'(in_cell_x) < MAP_DIM) && (32'(in_cell_y) < MAP_DIM);
  assign in_stall  = (state_r != S_IDLE);

  function automatic logic [SB-1:0] side_init(input logic signed [26:0] diff,
                                              input logic [23:0] delta);
    logic [25:0] d;
    logic [49:0] p;
    d = diff[26] ? 26'd0 : diff[25:0];
    p = d * delta;
    return SB'(p >> FRAC_BITS);
  endfunction

  // setup values (one multiply pair per cycle, in S_SETUP)
  logic signed [26:0] one_s, bx, by;
  assign one_s = 27'sd1 <<< FRAC_BITS;
  assign bx = (27'(mx_r) <<< FRAC_BITS);
  assign by = (27'(my_r) <<< FRAC_BITS);

  // step decision and landing
  logic take_x;
  logic signed [CB+1:0] nmx, nmy;
  assign take_x = sdx_r < sdy_r;
  assign nmx = take_x ? (dx_r < 0 ? mx_r - 1'b1 : mx_r + 1'b1) : mx_r;
  assign nmy = take_x ? my_r : (dy_r < 0 ? my_r - 1'b1 : my_r + 1'b1);

  logic cur_inside;
  assign cur_inside = (mx_r >= 0) && (32'(mx_r) < MAP_DIM) &&
                      (my_r >= 0) && (32'(my_r) < MAP_DIM);

  // perpendicular numerator
  logic signed [26:0] numv, magv;
  logic signed [17:0] dsel;
  logic [17:0] dmag;
  assign numv = side_r ? (by + (dy_r < 0 ? one_s : 27'sd0) - $signed({2'b0, py_r}))
                       : (bx + (dx_r < 0 ? one_s : 27'sd0) - $signed({2'b0, px_r}));
  assign magv = numv[26] ? -numv : numv;
  assign dsel = side_r ? dy_r : dx_r;
  assign dmag = dsel[17] ? 18'(-dsel) : 18'(dsel);

  logic [15:0] h_sat;
  logic [15:0] half_h;
  assign h_sat  = (div_q > DW'(HEIGHT_MAX)) ? HEIGHT_MAX : div_q[15:0];

  always_comb begin
    we = 1'b0; waddr = clr_r; wdata = 8'd0;
    raddr = AB'(32'(my_r[CB-1:0]) * MAP_DIM + 32'(mx_r[CB-1:0]));
    div_start = 1'b0;
    div_num = DW'(magv[25:0]) << FRAC_BITS;
    div_den = DW'(dmag);
    if (state_r == S_CLEAR) we = 1'b1;
    else if (state_r == S_IDLE && in_valid && in_req_type == REQ_WRITE && in_inside) begin
      we = 1'b1;
      waddr = AB'(32'(in_cell_y[CB-1:0]) * MAP_DIM + 32'(in_cell_x[CB-1:0]));
      wdata = in_cell_value;
    end
    if (state_r == S_DIV1) div_start = 1'b1;
    if (state_r == S_DIV2) begin
      div_start = 1'b1;
      div_num = DW'(SCREEN_SIZE) << FRAC_BITS;
      div_den = DW'(dist_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      clr_r     <= '0;
      out_valid <= 1'b0;
    end else begin
      // load a new result, or drop the one taken at this edge
      if (state_r == S_OUT && (!out_valid || !out_stall)) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
      case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (32'(clr_r) == CELLS - 1) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid && in_req_type == REQ_CAST) begin
            mx_r <= in_inside ? (CB+2)'(in_cell_x) : '1;
            my_r <= (CB+2)'(in_cell_y);
            px_r <= {1'b0, in_pos_x}; py_r <= {1'b0, in_pos_y};
            dx_r <= in_dir_x; dy_r <= in_dir_y;
            delx_r <= in_delta_x; dely_r <= in_delta_y;
            n_r <= '0;
            if (!in_inside) begin
              // no-hit result right away once the output is free
              state_r <= S_OUT; dist_r <= '0; side_r <= 1'b0;
            end else state_r <= S_SETUP;
          end
        end
        S_SETUP: begin
          sdx_r <= dx_r < 0 ? side_init(27'($signed({2'b0, px_r})) - bx, delx_r)
                            : side_init(bx + one_s - $signed({2'b0, px_r}), delx_r);
          sdy_r <= dy_r < 0 ? side_init(27'($signed({2'b0, py_r})) - by, dely_r)
                            : side_init(by + one_s - $signed({2'b0, py_r}), dely_r);
          state_r <= S_STEP;
        end
        S_STEP: begin
          if (take_x) begin sdx_r <= sdx_r + SB'(delx_r); side_r <= 1'b0; end
          else begin sdy_r <= sdy_r + SB'(dely_r); side_r <= 1'b1; end
          mx_r <= nmx; my_r <= nmy;
          n_r <= n_r + 1'b1;
          state_r <= S_READ;
        end
        S_READ: begin
          // address presented this cycle, data next
          state_r <= cur_inside ? S_CHECK : S_OUT;
          if (!cur_inside) begin dist_r <= '0; mx_r <= '1; end
        end
        S_CHECK: begin
          if (rd_q != 8'd0) state_r <= S_DIV1;
          else if (32'(n_r) >= 2 * MAP_DIM + 2) begin
            state_r <= S_OUT; dist_r <= '0; mx_r <= '1;
          end else state_r <= S_STEP;
        end
        S_DIV1: begin
          // zero direction on the hit axis: saturated distance, skip the wait
          if (dmag == 18'd0) begin
            dist_r  <= DIST_MAX;
            state_r <= S_DIV2;
          end else state_r <= S_DIV1W;
        end
        S_DIV1W: if (div_done) begin
          dist_r  <= (div_q > DW'(DIST_MAX)) ? DIST_MAX : div_q[23:0];
          state_r <= S_DIV2;
        end
        S_DIV2: state_r <= S_DIV2W;
        S_DIV2W: if (div_done) state_r <= S_OUT;
        S_OUT: begin
          if (!out_valid || !out_stall) begin
            if (&mx_r) begin
              out_hit_found <= 1'b0; out_hit_side <= 1'b0;
              out_hit_cell_x <= '0; out_hit_cell_y <= '0;
              out_wall_distance <= '0; out_line_height <= '0;
              out_draw_start <= '0; out_draw_end <= '0;
            end else begin
              out_hit_found <= 1'b1; out_hit_side <= side_r;
              out_hit_cell_x <= 5'(mx_r[CB-1:0]); out_hit_cell_y <= 5'(my_r[CB-1:0]);
              out_wall_distance <= dist_r;
              out_line_height <= (dist_r == '0) ? HEIGHT_MAX : h_sat;
              out_draw_start <= 9'(32'(half_h) > HALF ? 0 : HALF - 32'(half_h));
              out_draw_end <= 9'(32'(half_h) + HALF >= SCREEN_SIZE ?
                                 SCREEN_SIZE - 1 : 32'(half_h) + HALF);
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign half_h = ((dist_r == '0) ? HEIGHT_MAX : h_sat) >> 1;

`ifndef SYNTHESIS
  a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> in_stall) else $error("accepting while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_wall_distance)))
    else $error("result dropped under stall");
  a_no_write_cast: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CHECK) |-> !we) else $error("map write during walk");
`endif
endmodule
`default_nettype wire

FILE: dv/grid_dda_raycast_chk.sv
// ---------------------------------------------------------------------------
// grid_dda_raycast_chk: result predictor and scoreboard for the ray caster
// Mirrors the grid map from accepted write items, predicts each cast and
// compares every accepted result item field by field, in order.
// ---------------------------------------------------------------------------
module grid_dda_raycast_chk (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        in_req_type,
  input  logic [4:0]  in_cell_x,
  input  logic [4:0]  in_cell_y,
  input  logic [7:0]  in_cell_value,
  input  logic [23:0] in_pos_x,
  input  logic [23:0] in_pos_y,
  input  logic signed [17:0] in_dir_x,
  input  logic signed [17:0] in_dir_y,
  input  logic [23:0] in_delta_x,
  input  logic [23:0] in_delta_y,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        out_hit_found,
  input  logic        out_hit_side,
  input  logic [4:0]  out_hit_cell_x,
  input  logic [4:0]  out_hit_cell_y,
  input  logic [23:0] out_wall_distance,
  input  logic [15:0] out_line_height,
  input  logic [8:0]  out_draw_start,
  input  logic [8:0]  out_draw_end,
  output int          fail_count,
  output int          pending_hits
);
  import gdr_pkg::*;

  localparam int  DIM  = MAP_DIM_DEF;
  localparam int  SCR  = SCREEN_SIZE_DEF;
  localparam int  FB   = FRAC_BITS_DEF;
  localparam longint ONE = longint'(1) << FB;

  typedef struct packed {
    logic        found;
    logic        side;
    logic [4:0]  cx;
    logic [4:0]  cy;
    logic [23:0] wdist;
    logic [15:0] height;
    logic [8:0]  dstart;
    logic [8:0]  dend;
  } ray_hit_t;

  logic [7:0] shadow_map [DIM*DIM];
  ray_hit_t   hit_queue [$];

  function automatic bit on_map(longint x, longint y);
    return x >= 0 && x < DIM && y >= 0 && y < DIM;
  endfunction

  function automatic longint unsigned edge_dist(longint diff, longint unsigned dl);
    if (diff < 0) diff = 0;
    return (longint'(diff) * dl) >> FB;
  endfunction

  function automatic longint unsigned perp(longint num, longint dir);
    longint unsigned mag, d, q;
    mag = num < 0 ? -num : num;
    d   = dir < 0 ? -dir : dir;
    if (d == 0) return DIST_MAX;
    q = (mag << FB) / d;
    return q > DIST_MAX ? DIST_MAX : q;
  endfunction

  function automatic ray_hit_t cast_ray(logic [4:0] cx, logic [4:0] cy,
                                        logic [23:0] pxi, logic [23:0] pyi,
                                        logic signed [17:0] dxi,
                                        logic signed [17:0] dyi,
                                        logic [23:0] dlx, logic [23:0] dly);
    ray_hit_t r;
    longint mx, my, px, py, dx, dy, stx, sty, num;
    longint unsigned sdx, sdy, wdist, h, half, ds, de;
    bit side, hit;
    r = '0;
    mx = cx; my = cy; px = pxi; py = pyi; dx = dxi; dy = dyi;
    side = 0; hit = 0;
    if (!on_map(mx, my)) return r;
    if (dx < 0) begin stx = -1; sdx = edge_dist(px - mx*ONE, dlx); end
    else begin stx = 1; sdx = edge_dist((mx+1)*ONE - px, dlx); end
    if (dy < 0) begin sty = -1; sdy = edge_dist(py - my*ONE, dly); end
    else begin sty = 1; sdy = edge_dist((my+1)*ONE - py, dly); end
    for (int n = 0; n < 2*DIM+2; n++) begin
      if (sdx < sdy) begin sdx += dlx; mx += stx; side = 0; end
      else begin sdy += dly; my += sty; side = 1; end
      if (!on_map(mx, my)) break;
      if (shadow_map[my*DIM+mx] != 0) begin hit = 1; break; end
    end
    if (!hit) return r;
    if (!side) begin
      num = mx*ONE + (stx < 0 ? ONE : 0) - px;
      wdist = perp(num, dx);
    end else begin
      num = my*ONE + (sty < 0 ? ONE : 0) - py;
      wdist = perp(num, dy);
    end
    if (wdist == 0) h = HEIGHT_MAX;
    else begin
      h = (longint'(SCR) << FB) / wdist;
      if (h > HEIGHT_MAX) h = HEIGHT_MAX;
    end
    half = h / 2;
    ds = half > SCR/2 ? 0 : SCR/2 - half;
    de = half + SCR/2;
    if (de >= SCR) de = SCR - 1;
    r.found = 1; r.side = side; r.cx = mx[4:0]; r.cy = my[4:0];
    r.wdist = wdist[23:0]; r.height = h[15:0]; r.dstart = ds[8:0]; r.dend = de[8:0];
    return r;
  endfunction

  always @(posedge clk) begin
    ray_hit_t e;
    if (!rst_n) begin
      foreach (shadow_map[i]) shadow_map[i] = '0;
      hit_queue.delete();
      fail_count <= 0;
      pending_hits <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        if (in_req_type == REQ_WRITE)
          shadow_map[in_cell_y*DIM + in_cell_x] = in_cell_value;
        else
          hit_queue.push_back(cast_ray(in_cell_x, in_cell_y, in_pos_x, in_pos_y,
                                       in_dir_x, in_dir_y, in_delta_x, in_delta_y));
      end
      if (out_valid && !out_stall) begin
        if (hit_queue.size() == 0) begin
          $error("result item with nothing expected");
          fail_count <= fail_count + 1;
        end else begin
          e = hit_queue.pop_front();
          if ({out_hit_found, out_hit_side, out_hit_cell_x, out_hit_cell_y,
               out_wall_distance, out_line_height, out_draw_start,
               out_draw_end} !== e) begin
            if (out_hit_found !== e.found)
              $error("hit_found exp %0d got %0d", e.found, out_hit_found);
            if (out_hit_side !== e.side)
              $error("hit_side exp %0d got %0d", e.side, out_hit_side);
            if (out_hit_cell_x !== e.cx)
              $error("hit_cell_x exp %0d got %0d", e.cx, out_hit_cell_x);
            if (out_hit_cell_y !== e.cy)
              $error("hit_cell_y exp %0d got %0d", e.cy, out_hit_cell_y);
            if (out_wall_distance !== e.wdist)
              $error("wall_distance exp %0d got %0d", e.wdist, out_wall_distance);
            if (out_line_height !== e.height)
              $error("line_height exp %0d got %0d", e.height, out_line_height);
            if (out_draw_start !== e.dstart)
              $error("draw_start exp %0d got %0d", e.dstart, out_draw_start);
            if (out_draw_end !== e.dend)
              $error("draw_end exp %0d got %0d", e.dend, out_draw_end);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending_hits <= hit_queue.size();
    end
  end
endmodule

FILE: dv/grid_dda_raycast_tb.sv
// ---------------------------------------------------------------------------
// grid_dda_raycast_tb: stimulus and verdict for the grid ray caster
// Builds maps with walls, casts directed and random rays under random idling
// on both channels, and lets the checker score every result item.
// ---------------------------------------------------------------------------
module grid_dda_raycast_tb;
  import gdr_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_req_type;
  logic [4:0]  in_cell_x;
  logic [4:0]  in_cell_y;
  logic [7:0]  in_cell_value;
  logic [23:0] in_pos_x;
  logic [23:0] in_pos_y;
  logic signed [17:0] in_dir_x;
  logic signed [17:0] in_dir_y;
  logic [23:0] in_delta_x;
  logic [23:0] in_delta_y;
  logic        out_valid;
  logic        out_stall;
  logic        out_hit_found;
  logic        out_hit_side;
  logic [4:0]  out_hit_cell_x;
  logic [4:0]  out_hit_cell_y;
  logic [23:0] out_wall_distance;
  logic [15:0] out_line_height;
  logic [8:0]  out_draw_start;
  logic [8:0]  out_draw_end;
  int          fail_count;
  int          pending_hits;

  // idle percentages per side, changed between phases
  int          send_idle_pct;
  int          recv_idle_pct;
  longint      cycle_count = 0;

  localparam longint CYCLE_LIMIT = 2_000_000;

  grid_dda_raycast dut (.*);

  grid_dda_raycast_chk chk (.*);

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // Random receiver stall; a draw each cycle at the given rate.
  always @(posedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // Watchdog: end the run on a stuck handshake.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Present one item and hold it until accepted; idle first at random.
  task automatic send_item(logic rt, logic [4:0] cx, logic [4:0] cy, logic [7:0] cv,
                           logic [23:0] px, logic [23:0] py,
                           logic [17:0] dx, logic [17:0] dy,
                           logic [23:0] dlx, logic [23:0] dly);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= rt; in_cell_x <= cx; in_cell_y <= cy; in_cell_value <= cv;
    in_pos_x <= px; in_pos_y <= py; in_dir_x <= dx; in_dir_y <= dy;
    in_delta_x <= dlx; in_delta_y <= dly;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic put_cell(logic [4:0] cx, logic [4:0] cy, logic [7:0] v);
    send_item(REQ_WRITE, cx, cy, v, 24'($urandom), 24'($urandom), 18'($urandom),
              18'($urandom), 24'($urandom), 24'($urandom));
  endtask

  // Ray from inside the start cell with sensible deltas, or with wild random fields.
  task automatic cast_random(bit wild);
    logic [4:0] cx, cy;
    logic [17:0] dx, dy;
    logic [23:0] px, py, dlx, dly;
    cx = 5'($urandom); cy = 5'($urandom);
    dx = 18'($urandom); dy = 18'($urandom);
    if (wild) begin
      px = 24'($urandom); py = 24'($urandom);
      dlx = 24'($urandom); dly = 24'($urandom);
    end else begin
      px = {3'b0, cx, 16'(($urandom))};
      py = {3'b0, cy, 16'(($urandom))};
      dlx = 24'($urandom_range(24'h0FFFFF));
      dly = 24'($urandom_range(24'h0FFFFF));
      if ($urandom_range(9) == 0) dx = 0;
      if ($urandom_range(9) == 0) dy = 0;
    end
    send_item(REQ_CAST, cx, cy, 8'd0, px, py, dx, dy, dlx, dly);
  endtask

  initial begin
    rst_n = 0; in_valid = 0; in_req_type = 0; in_cell_x = 0; in_cell_y = 0;
    in_cell_value = 0; in_pos_x = 0; in_pos_y = 0; in_dir_x = 0; in_dir_y = 0;
    in_delta_x = 0; in_delta_y = 0;
    send_idle_pct = 18; recv_idle_pct = 48;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty map, so the ray walks off the edge.
    send_item(REQ_CAST, 5'd16, 5'd16, 8'd0, 24'h108000, 24'h108000,
              18'sh10000, 18'sh0, 24'h10000, 24'hFFFFFF);
    // Border wall ring, including the corners and the maximum value.
    for (int i = 0; i < 32; i++) begin
      put_cell(5'(i), 5'd0, 8'hFF);
      put_cell(5'(i), 5'd31, 8'h01);
      put_cell(5'd0, 5'(i), 8'h80);
      put_cell(5'd31, 5'(i), 8'h7F);
    end
    // Directed casts: each axis both ways, zero direction, extreme fields.
    send_item(REQ_CAST, 5'd16, 5'd16, 8'd0, 24'h108000, 24'h108000,
              18'sh10000, 18'sh0, 24'h10000, 24'hFFFFFF);
    send_item(REQ_CAST, 5'd16, 5'd16, 8'd0, 24'h108000, 24'h108000,
              18'sh20000, 18'sh0, 24'h8000, 24'hFFFFFF);
    send_item(REQ_CAST, 5'd16, 5'd16, 8'd0, 24'h108000, 24'h108000,
              18'sh0, 18'sh1FFFF, 24'hFFFFFF, 24'h10000);
    send_item(REQ_CAST, 5'd16, 5'd16, 8'd0, 24'h108000, 24'h108000,
              18'sh0, 18'sh30000, 24'hFFFFFF, 24'h0);
    // Start cell is a wall: never reported, the walk moves on.
    send_item(REQ_CAST, 5'd0, 5'd5, 8'd0, 24'h058000, 24'h058000,
              18'sh10000, 18'sh0, 24'h10000, 24'hFFFFFF);
    // Origin behind the start edge; zero distance next to the wall.
    send_item(REQ_CAST, 5'd30, 5'd4, 8'd0, 24'hFFFFFF, 24'h0,
              18'sh10000, 18'sh0, 24'h0, 24'hFFFFFF);
    send_item(REQ_CAST, 5'd1, 5'd1, 8'd0, 24'h010000, 24'h010000,
              18'sh3FFFF, 18'sh3FFFF, 24'h1, 24'h1);
    // Write outside the map cannot happen with 5-bit cells; rewrite to empty.
    put_cell(5'd31, 5'd31, 8'h00);
    send_item(REQ_CAST, 5'd30, 5'd30, 8'd0, 24'h1E8000, 24'h1E8000,
              18'sh10000, 18'sh10000, 24'h16A09, 24'h16A09);

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = ph == 0 ? 18 : (ph == 1 ? 48 : 0);
      recv_idle_pct = ph == 0 ? 48 : (ph == 1 ? 18 : 0);
      for (int k = 0; k < 520; k++) begin
        // Drop walls at random, sometimes clear one, mostly cast.
        if ($urandom_range(9) < 3)
          put_cell(5'($urandom), 5'($urandom),
                   $urandom_range(3) == 0 ? 8'h00 : 8'($urandom));
        else
          cast_random($urandom_range(9) == 0);
      end
    end
    in_valid <= 1'b0;
    @(posedge clk);

    while (pending_hits != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (fail_count == 0 && pending_hits == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end
endmodule

FILE: grid_dda_raycast.f
design/gdr_pkg.sv
design/gdr_div.sv
design/grid_dda_raycast.sv
dv/grid_dda_raycast_chk.sv
dv/grid_dda_raycast_tb.sv
